// ===== src/ax25fb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the FCS byte update for the AX.25 UI frame builder.
// No dependencies.
package ax25fb_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CALL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_SSID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CALL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SSID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PID       = 3'd5;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [7:0]  SPACE_CHAR    = 8'h20;
  localparam logic [7:0]  CONTROL_RESET = 8'h03;
  localparam logic [7:0]  PID_RESET     = 8'hF0;
  localparam logic [15:0] FCS_INIT      = 16'hFFFF;
  localparam logic [15:0] FCS_POLY      = 16'h8408;
  // top three bits of an SSID byte; the low bit is the address extension bit
  localparam logic [2:0]  SSID_TOP      = 3'b011;

  typedef enum logic [3:0] {
    S_FLAG_OPEN,
    S_DEST_CALL,
    S_DEST_SSID,
    S_SRC_CALL,
    S_SRC_SSID,
    S_CONTROL,
    S_PID,
    S_PAYLOAD,
    S_FCS_LO,
    S_FCS_HI,
    S_FLAG_CLOSE
  } seq_state_t;

  // CRC-16/X-25, reflected, one byte
  function automatic logic [15:0] fcs_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ax25fb_in_if.sv =====
`timescale 1ns / 1ps
// Payload input channel: valid/ready plus one payload byte and its last-byte mark.
// No dependencies.
interface ax25fb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ===== src/ax25fb_out_if.sv =====
`timescale 1ns / 1ps
// Encoded frame output channel: valid/ready plus one frame byte and the end mark.
// No dependencies.
interface ax25fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== src/ax25fb_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: valid/ready, register index and write data.
// Depends on ax25fb_pkg for the index width.
interface ax25fb_cfg_if #(
  parameter int unsigned DATA_W = 48
);
  import ax25fb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== src/ax25_ui_frame_builder_unit.sv =====
`timescale 1ns / 1ps
// AX.25 UI frame builder top level: byte sequencer, FCS and output register.
// Depends on ax25fb_pkg, ax25fb_in_if, ax25fb_out_if and ax25fb_cfg_if.
//
// Usage
//  - in_ch takes payload bytes; last_byte marks the final byte of a frame.
//  - out_ch gives the encoded frame one byte per item; frame_end is set on
//    the closing flag only. No bit stuffing is done.
//  - cfg_ch writes the address, SSID, control and PID registers; it is always
//    ready. Unknown indexes are dropped. Write only while the block is idle.
//  - The first payload item of a frame costs 2*CALLSIGN_CHARS+6 output bytes
//    (flag, two addresses, control, PID, payload), 18 at the default; a middle
//    item costs 1; a last item adds FCS low, FCS high and closing flag (+3).
//    The sequencer emits one byte per cycle while out_ch is not stalled, so an
//    item holds in_ch until its final byte is registered; mid-frame payload streams
//    at one item per cycle while out_ch does not stall. An accepted item
//    waits in the hold stage before its first byte enters the output register.
//  - Stall: out_ch has a single output register; while it is full and not
//    taken the sequencer freezes and in_ch drops ready if an item is held.
//    The next item is taken in the same cycle as the last one's final byte is registered.
//  - Reset (rst_n low, synchronous) empties both stages, closes any open
//    frame, resets the FCS and loads the register reset values.
module ax25_ui_frame_builder_unit
  import ax25fb_pkg::*;
#(
  parameter int unsigned CALLSIGN_CHARS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  ax25fb_in_if.sink      in_ch,
  ax25fb_out_if.source   out_ch,
  ax25fb_cfg_if.sink     cfg_ch
);

  localparam int unsigned CALL_W = 8 * CALLSIGN_CHARS;
  localparam int unsigned CNT_W  = (CALLSIGN_CHARS > 1) ? $clog2(CALLSIGN_CHARS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALLSIGN_CHARS - 1);

  // configuration registers
  logic [CALL_W-1:0] dest_call_r, src_call_r;
  logic [3:0]        dest_ssid_r, src_ssid_r;
  logic [7:0]        control_r, pid_r;

  // held input item
  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] payload_r;
  logic       last_r;

  // sequencer
  seq_state_t        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CALL_W-1:0] shift_r, shift_nxt;
  logic              ended_r, ended_nxt;
  logic [15:0]       fcs_r, fcs_nxt;
  logic              in_frame_r, in_frame_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       frame_end_r;

  logic       advance, item_done, in_fire, covered, cur_end, blank;
  logic [7:0] cur_byte, cur_char;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_call_r <= '0;
      src_call_r  <= '0;
      dest_ssid_r <= '0;
      src_ssid_r  <= '0;
      control_r   <= CONTROL_RESET;
      pid_r       <= PID_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_DEST_CALL: dest_call_r <= CALL_W'(cfg_ch.wr_data);
        CFG_DEST_SSID: dest_ssid_r <= cfg_ch.wr_data[3:0];
        CFG_SRC_CALL:  src_call_r  <= CALL_W'(cfg_ch.wr_data);
        CFG_SRC_SSID:  src_ssid_r  <= cfg_ch.wr_data[3:0];
        CFG_CONTROL:   control_r   <= cfg_ch.wr_data[7:0];
        CFG_PID:       pid_r       <= cfg_ch.wr_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer advances when an item is held and the output register is free or being drained
  assign advance      = hold_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !hold_valid_r || (advance && item_done);
  assign in_fire      = in_ch.valid && in_ch.ready;

  // top character of the working callsign, blanked from the first zero on
  assign cur_char = shift_r[CALL_W-1 -: 8];
  assign blank    = ended_r || (cur_char == 8'h00);

  always_comb begin
    cur_byte     = FLAG_BYTE;
    cur_end      = 1'b0;
    covered      = 1'b0;
    item_done    = 1'b0;
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    ended_nxt    = ended_r;
    fcs_nxt      = fcs_r;
    in_frame_nxt = in_frame_r;

    if (advance) begin
      unique case (st_r)
        S_FLAG_OPEN: begin
          fcs_nxt   = FCS_INIT;
          shift_nxt = dest_call_r;
          ended_nxt = 1'b0;
          cnt_nxt   = '0;
          st_nxt    = S_DEST_CALL;
        end
        S_DEST_CALL, S_SRC_CALL: begin
          cur_byte  = blank ? {SPACE_CHAR[6:0], 1'b0} : {cur_char[6:0], 1'b0};
          covered   = 1'b1;
          ended_nxt = blank;
          shift_nxt = shift_r << 8;
          if (cnt_r == CNT_LAST) begin
            st_nxt = (st_r == S_DEST_CALL) ? S_DEST_SSID : S_SRC_SSID;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        S_DEST_SSID: begin
          cur_byte  = {SSID_TOP, dest_ssid_r, 1'b0};
          covered   = 1'b1;
          shift_nxt = src_call_r;
          ended_nxt = 1'b0;
          cnt_nxt   = '0;
          st_nxt    = S_SRC_CALL;
        end
        S_SRC_SSID: begin
          cur_byte = {SSID_TOP, src_ssid_r, 1'b1};
          covered  = 1'b1;
          st_nxt   = S_CONTROL;
        end
        S_CONTROL: begin
          cur_byte = control_r;
          covered  = 1'b1;
          st_nxt   = S_PID;
        end
        S_PID: begin
          cur_byte = pid_r;
          covered  = 1'b1;
          st_nxt   = S_PAYLOAD;
        end
        S_PAYLOAD: begin
          cur_byte     = payload_r;
          covered      = 1'b1;
          in_frame_nxt = 1'b1;
          if (last_r) begin
            st_nxt = S_FCS_LO;
          end else begin
            item_done = 1'b1;
          end
        end
        S_FCS_LO: begin
          cur_byte = ~fcs_r[7:0];
          st_nxt   = S_FCS_HI;
        end
        S_FCS_HI: begin
          cur_byte = ~fcs_r[15:8];
          st_nxt   = S_FLAG_CLOSE;
        end
        S_FLAG_CLOSE: begin
          cur_end      = 1'b1;
          fcs_nxt      = FCS_INIT;
          in_frame_nxt = 1'b0;
          item_done    = 1'b1;
        end
        default: ;
      endcase
      if (covered) begin
        fcs_nxt = fcs_byte(fcs_r, cur_byte);
      end
    end

    // hold stage: a new item starts with the header only when no frame is open
    hold_valid_nxt = hold_valid_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
      st_nxt         = in_frame_nxt ? S_PAYLOAD : S_FLAG_OPEN;
    end else if (advance && item_done) begin
      hold_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_FLAG_OPEN;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      in_frame_r   <= 1'b0;
      fcs_r        <= FCS_INIT;
      cnt_r        <= '0;
      ended_r      <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      in_frame_r   <= in_frame_nxt;
      fcs_r        <= fcs_nxt;
      cnt_r        <= cnt_nxt;
      ended_r      <= ended_nxt;
    end
  end

  // registers without reset: callsign shift, held payload item and output byte
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (in_fire) begin
      payload_r <= in_ch.payload_byte;
      last_r    <= in_ch.last_byte;
    end
    if (advance) begin
      out_byte_r  <= cur_byte;
      frame_end_r <= cur_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;

endmodule

// ===== bench/ax25_ui_frame_builder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ax25_ui_frame_builder_unit: directed and random payload frames,
// predicted frame bytes checked one by one at the output. Needs ax25fb_pkg and the three
// channel interfaces; drives everything itself.
module ax25_ui_frame_builder_unit_tb;
  import ax25fb_pkg::*;

  localparam int CALL_CHARS   = 6;
  localparam int CALL_W       = 8 * CALL_CHARS;
  localparam int CFG_DATA_W   = 48;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_WAIT     = 12;   // longest per-item idle on either side
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 1500; // cycles without any handshake
  localparam int END_SETTLE   = 4;    // settling margin once the block is idle
  localparam int MAX_REPORTS  = 50;

  // indexes the block has no register for; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    logic [7:0] val;
    logic       end_mark;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  ax25fb_in_if                          in_bus ();
  ax25fb_out_if                         out_bus ();
  ax25fb_cfg_if #(.DATA_W(CFG_DATA_W))  cfg_bus ();

  ax25_ui_frame_builder_unit #(
    .CALLSIGN_CHARS(CALL_CHARS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame prediction: own copy of the registers, the open-frame flag and the FCS.
  // Every accepted payload item appends its frame bytes to pending_frame_bytes.
  // ---------------------------------------------------------------------------
  logic [CALL_W-1:0] shadow_dest_call = '0;
  logic [3:0]        shadow_dest_ssid = '0;
  logic [CALL_W-1:0] shadow_src_call  = '0;
  logic [3:0]        shadow_src_ssid  = '0;
  logic [7:0]        shadow_control   = CONTROL_RESET;
  logic [7:0]        shadow_pid       = PID_RESET;
  logic              frame_open       = 1'b0;
  logic [15:0]       fcs_reg          = FCS_INIT;

  frame_byte_t pending_frame_bytes[$];

  int  fault_count   = 0;
  int  items_sent    = 0;
  int  frames_sent   = 0;
  int  bytes_checked = 0;
  int  cfg_writes    = 0;
  bit  no_gaps       = 1'b0; // set for stretches with back-to-back traffic
  int  hold_ticket   = 0;    // bumped by a test to ask the receiver for a long hold-off

  // CRC-16/X-25, reflected, one byte at a time
  function automatic logic [15:0] crc16_x25_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ FCS_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void queue_frame_byte(input logic [7:0] b, input logic end_mark,
                                           input logic in_fcs);
    frame_byte_t fb;
    fb.val      = b;
    fb.end_mark = end_mark;
    pending_frame_bytes.push_back(fb);
    if (in_fcs) fcs_reg = crc16_x25_step(fcs_reg, b);
  endfunction

  // callsign characters shifted up by one; from the first zero on, all spaces
  function automatic void queue_address(input logic [CALL_W-1:0] call, input logic [3:0] ssid,
                                        input logic is_source);
    logic [7:0] ch;
    logic       blanked;
    blanked = 1'b0;
    for (int i = 0; i < CALL_CHARS; i++) begin
      ch = call[8*(CALL_CHARS-1-i) +: 8];
      if (ch == 8'h00) blanked = 1'b1;
      if (blanked) ch = SPACE_CHAR;
      queue_frame_byte({ch[6:0], 1'b0}, 1'b0, 1'b1);
    end
    // SSID byte: 011 on top, SSID, then the address extension bit (source only)
    queue_frame_byte({SSID_TOP, ssid, is_source}, 1'b0, 1'b1);
  endfunction

  function automatic void encode_payload_byte(input logic [7:0] b, input logic is_last);
    logic [15:0] fcs;
    if (!frame_open) begin
      fcs_reg = FCS_INIT;
      queue_frame_byte(FLAG_BYTE, 1'b0, 1'b0);
      queue_address(shadow_dest_call, shadow_dest_ssid, 1'b0);
      queue_address(shadow_src_call, shadow_src_ssid, 1'b1);
      queue_frame_byte(shadow_control, 1'b0, 1'b1);
      queue_frame_byte(shadow_pid, 1'b0, 1'b1);
      frame_open = 1'b1;
    end
    queue_frame_byte(b, 1'b0, 1'b1);
    if (is_last) begin
      fcs = fcs_reg ^ FCS_INIT;
      queue_frame_byte(fcs[7:0], 1'b0, 1'b0);
      queue_frame_byte(fcs[15:8], 1'b0, 1'b0);
      queue_frame_byte(FLAG_BYTE, 1'b1, 1'b0);
      frame_open  = 1'b0;
      fcs_reg     = FCS_INIT;
      frames_sent++;
    end
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEST_CALL: shadow_dest_call = data[CALL_W-1:0];
      CFG_DEST_SSID: shadow_dest_ssid = data[3:0];
      CFG_SRC_CALL:  shadow_src_call  = data[CALL_W-1:0];
      CFG_SRC_SSID:  shadow_src_ssid  = data[3:0];
      CFG_CONTROL:   shadow_control   = data[7:0];
      CFG_PID:       shadow_pid       = data[7:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Valid is never dropped between back-to-back items, only before a gap,
  // so no signal sees two nonblocking writes in one step.
  // ---------------------------------------------------------------------------
  task automatic send_payload(input logic [7:0] b, input logic is_last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.payload_byte <= b;
    in_bus.last_byte    <= is_last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    encode_payload_byte(b, is_last);
    items_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_payload(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    apply_reg_write(idx, data);
    cfg_writes++;
  endtask

  task automatic load_settings(input logic [CALL_W-1:0] dest_call, input logic [3:0] dest_ssid,
                               input logic [CALL_W-1:0] src_call, input logic [3:0] src_ssid,
                               input logic [7:0] control, input logic [7:0] pid);
    write_reg(CFG_DEST_CALL, CFG_DATA_W'(dest_call));
    write_reg(CFG_DEST_SSID, CFG_DATA_W'(dest_ssid));
    write_reg(CFG_SRC_CALL,  CFG_DATA_W'(src_call));
    write_reg(CFG_SRC_SSID,  CFG_DATA_W'(src_ssid));
    write_reg(CFG_CONTROL,   CFG_DATA_W'(control));
    write_reg(CFG_PID,       CFG_DATA_W'(pid));
    cfg_bus.valid <= 1'b0;
  endtask

  // block is idle once every predicted byte has come out (every item yields bytes);
  // always waits on the clock first, so valid is not written twice in one step
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_frame_bytes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per item, a long hold-off on request, and the check.
  // ---------------------------------------------------------------------------
  int sink_wait = 0;
  int hold_left = 0;
  int hold_seen = 0;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_sink
    frame_byte_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      bytes_checked++;
      if (pending_frame_bytes.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: frame byte with nothing expected, expected none, actual %02h/%0b",
                   $time, out_bus.out_byte, out_bus.frame_end);
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_bus.out_byte !== want.val)
          report_mismatch("out_byte", want.val, out_bus.out_byte);
        if (out_bus.frame_end !== want.end_mark)
          report_mismatch("frame_end", 8'(want.end_mark), 8'(out_bus.frame_end));
      end
      sink_wait = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_bus.ready <= (sink_wait == 0 && hold_left == 0);
  end

  // ends the run if no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: empty callsigns go out as spaces, control 03, PID F0;
  // a one-item frame and payload extremes
  task automatic test_reset_defaults();
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h80, 1'b1);
  endtask

  // short callsigns: a zero mid-way blanks the rest even if later chars are set;
  // a zero first blanks the lot. SSID top, control/PID at opposite extremes.
  task automatic test_short_callsigns();
    wait_idle();
    load_settings(48'h4142_0043_4445, 4'hF, 48'h0058_595A_3132, 4'h0, 8'h00, 8'hFF);
    send_payload(8'h01, 1'b0);
    send_payload(8'h7E, 1'b0); // flag value as payload, no stuffing expected
    send_payload(8'hFE, 1'b1);
  endtask

  // all-ones callsign (top bit lost in the shift), full source callsign,
  // and writes to unused indexes that must change nothing
  task automatic test_extreme_fields();
    wait_idle();
    load_settings(48'hFFFF_FFFF_FFFF, 4'h0, 48'h4E30_4341_4C4C, 4'hF, 8'hFF, 8'h00);
    @(posedge clk);
    write_reg(CFG_SPARE_A, {$urandom(), 16'($urandom())});
    write_reg(CFG_SPARE_B, {$urandom(), 16'($urandom())});
    cfg_bus.valid <= 1'b0;
    send_payload(8'h55, 1'b0);
    send_payload(8'hAA, 1'b1);
  endtask

  // receiver holds off for a long stretch while payload keeps coming,
  // so the output register fills and the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    no_gaps = 1'b1;
    hold_ticket++;
    send_frame(8);
    no_gaps = 1'b0;
  endtask

  function automatic logic [CALL_W-1:0] random_callsign();
    logic [CALL_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = '0;
      1: c = '1;
      default: begin
        for (int i = 0; i < CALL_CHARS; i++) begin
          c[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] random_field(input logic [7:0] top);
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return top;
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  // phases of fresh settings, each with a few frames; mostly short frames,
  // now and then a long one; some phases run with no idling at all
  task automatic test_random_traffic();
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      load_settings(random_callsign(), 4'(random_field(8'h0F)),
                    random_callsign(), 4'(random_field(8'h0F)),
                    random_field(8'hFF), random_field(8'hFF));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        send_frame(len);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin : main
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.payload_byte  = 8'h00;
    in_bus.last_byte     = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = CFG_DEST_CALL;
    cfg_bus.wr_data      = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_short_callsigns();
    test_extreme_fields();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_frame_bytes.size() != 0) begin
      fault_count++;
      $display("%0t: %0d frame bytes never arrived", $time, pending_frame_bytes.size());
    end

    $display("summary: %0d frames from %0d payload items, %0d frame bytes compared",
             frames_sent, items_sent, bytes_checked);
    $display("summary: %0d register writes, %0d faults", cfg_writes, fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
